FILE: rtl/pmfd_pkg.sv
// ---------------------------------------------------------------------------
// pmfd_pkg
// Shared types and constants of the paged monochrome draw engine.
// ---------------------------------------------------------------------------
package pmfd_pkg;

   localparam int COORD_W = 10;
   localparam int IDX_W   = 16;
   localparam int WIDTH_W = 9;
   localparam int HEIGHT_W = 7;

   typedef enum logic [2:0] {
      ACT_CLEAR = 3'd0,
      ACT_PIXEL = 3'd1,
      ACT_HLINE = 3'd2,
      ACT_VLINE = 3'd3,
      ACT_RECT  = 3'd4,
      ACT_FILL  = 3'd5,
      ACT_READ  = 3'd6,
      ACT_NONE  = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ROW_Y1   = 2'd0,
      ROW_Y2   = 2'd1,
      ROW_LO   = 2'd2,
      ROW_NEXT = 2'd3
   } row_sel_type;

   typedef struct packed {
      logic        load;
      logic        seg_h;
      row_sel_type row_sel;
      logic        seg_v;
      logic        col_x2;
      logic        step;
      logic        clr_start;
      logic        clr_full;
      logic        clr_step;
      logic        rd_pix;
      logic        wr_pix;
      logic        rd_byte;
      logic        rsp_load;
      logic        rsp_ok;
      logic        rsp_rd;
   } cmd_type;

   typedef struct packed {
      logic seg_last;
      logic row_last;
      logic pix_ok;
      logic clr_done;
      logic addr_ok;
      logic rsp_free;
   } status_type;

endpackage

FILE: rtl/pmfd_if.sv
// ---------------------------------------------------------------------------
// pmfd_if
// Request and response channels of the paged monochrome draw engine.
// ---------------------------------------------------------------------------
interface draw_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        action;
   logic signed [9:0] x1;
   logic signed [9:0] y1;
   logic signed [9:0] x2;
   logic signed [9:0] y2;
   logic [10:0]       byte_addr;

   modport source (output valid, action, x1, y1, x2, y2, byte_addr, input ready);
   modport sink   (input valid, action, x1, y1, x2, y2, byte_addr, output ready);
endinterface

interface draw_rsp_if;
   logic       valid;
   logic       ready;
   logic       ok;
   logic [7:0] read_data;

   modport source (output valid, ok, read_data, input ready);
   modport sink   (input valid, ok, read_data, output ready);
endinterface

FILE: rtl/pmfd_ram.sv
// ---------------------------------------------------------------------------
// pmfd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pmfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/pmfd_ctrl.sv
// ---------------------------------------------------------------------------
// pmfd_ctrl
// Command sequencer: splits draw requests into segments and pixel steps.
// ---------------------------------------------------------------------------
module pmfd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_action,
   output logic                 req_ready,
   input  pmfd_pkg::status_type status,
   output pmfd_pkg::cmd_type    cmd
);
   import pmfd_pkg::*;

   typedef enum logic [9:0] {
      ST_BOOT  = 10'b0000000001,
      ST_BCLR  = 10'b0000000010,
      ST_IDLE  = 10'b0000000100,
      ST_START = 10'b0000001000,
      ST_CLR   = 10'b0000010000,
      ST_CHK   = 10'b0000100000,
      ST_RD    = 10'b0001000000,
      ST_WR    = 10'b0010000000,
      ST_RWAIT = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   state_type  state_ff, state_in;
   action_type act_ff, act_in;
   logic [1:0] edge_ff, edge_in;
   logic       ok_ff, ok_in;
   logic       rdres_ff, rdres_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      edge_in  = edge_ff;
      ok_in    = ok_ff;
      rdres_in = rdres_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_BOOT: begin
            cmd.clr_start = 1'b1;
            cmd.clr_full  = 1'b1;
            state_in      = ST_BCLR;
         end
         ST_BCLR: begin
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               act_in   = action_type'(req_action);
               ok_in    = 1'b0;
               rdres_in = 1'b0;
               edge_in  = 2'd0;
               state_in = ST_START;
            end
         end
         ST_START: begin
            unique case (act_ff)
               ACT_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  state_in      = ST_CLR;
               end
               ACT_PIXEL, ACT_HLINE, ACT_RECT: begin
                  cmd.seg_h   = 1'b1;
                  cmd.row_sel = ROW_Y1;
                  state_in    = ST_CHK;
               end
               ACT_VLINE: begin
                  cmd.seg_v = 1'b1;
                  state_in  = ST_CHK;
               end
               ACT_FILL: begin
                  cmd.seg_h   = 1'b1;
                  cmd.row_sel = ROW_LO;
                  state_in    = ST_CHK;
               end
               ACT_READ: begin
                  if (status.addr_ok) begin
                     cmd.rd_byte = 1'b1;
                     state_in    = ST_RWAIT;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_CLR: begin
            if (status.clr_done) begin
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         ST_CHK: begin
            state_in = ST_RD;
         end
         ST_RD: begin
            if (status.pix_ok) begin
               cmd.rd_pix = 1'b1;
               state_in   = ST_WR;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WR: begin
            cmd.wr_pix = 1'b1;
            state_in   = ST_CHK;
            if (!status.seg_last) begin
               cmd.step = 1'b1;
            end else if (act_ff == ACT_RECT) begin
               // Outline order: row y1, column x1, row y2, column x2.
               edge_in = edge_ff + 2'd1;
               unique case (edge_ff)
                  2'd0: begin
                     cmd.seg_v = 1'b1;
                  end
                  2'd1: begin
                     cmd.seg_h   = 1'b1;
                     cmd.row_sel = ROW_Y2;
                  end
                  2'd2: begin
                     cmd.seg_v  = 1'b1;
                     cmd.col_x2 = 1'b1;
                  end
                  default: begin
                     ok_in    = 1'b1;
                     state_in = ST_DONE;
                  end
               endcase
            end else if (act_ff == ACT_FILL && !status.row_last) begin
               cmd.seg_h   = 1'b1;
               cmd.row_sel = ROW_NEXT;
            end else begin
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_RWAIT: begin
            ok_in    = 1'b1;
            rdres_in = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_ok   = ok_ff;
               cmd.rsp_rd   = rdres_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_BOOT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
         act_ff   <= ACT_NONE;
         edge_ff  <= 2'd0;
         ok_ff    <= 1'b0;
         rdres_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         act_ff   <= act_in;
         edge_ff  <= edge_in;
         ok_ff    <= ok_in;
         rdres_ff <= rdres_in;
      end
   end

endmodule

FILE: rtl/pmfd_dp.sv
// ---------------------------------------------------------------------------
// pmfd_dp
// Draw datapath: coordinate walker, pixel check, store and response register.
// ---------------------------------------------------------------------------
module pmfd_dp #(
   parameter int STORE_DEPTH = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pmfd_pkg::cmd_type    cmd,
   output pmfd_pkg::status_type status,
   input  logic [2:0]           req_action,
   input  logic signed [9:0]    req_x1,
   input  logic signed [9:0]    req_y1,
   input  logic signed [9:0]    req_x2,
   input  logic signed [9:0]    req_y2,
   input  logic [10:0]          req_byte_addr,
   input  logic [8:0]           width_px,
   input  logic [6:0]           height_px,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_ok,
   output logic [7:0]           rsp_read_data
);
   import pmfd_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(STORE_DEPTH);

   logic signed [COORD_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic [10:0]               addr_ff;
   logic signed [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic                      axis_v_ff, axis_v_in;
   logic signed [COORD_W-1:0] xlo, xhi, ylo, yhi;
   logic [IDX_W-1:0]          limit_raw, limit_now, limit_ff;
   logic                      x_in_range, y_in_range;
   logic [14:0]               page_off;
   logic [IDX_W-1:0]          idx_now, idx_ff;
   logic                      pix_ok_ff;
   logic [7:0]                mask_ff;
   logic [CW-1:0]             cnt_ff, end_ff;
   logic                      ram_we, ram_re;
   logic [AW-1:0]             ram_waddr, ram_raddr;
   logic [7:0]                ram_wdata, ram_rdata;
   logic [IDX_W-1:0]          byte_idx;
   logic                      rsp_valid_ff, rsp_ok_ff;
   logic [7:0]                rsp_data_ff;

   assign xlo = (x1_ff < x2_ff) ? x1_ff : x2_ff;
   assign xhi = (x1_ff < x2_ff) ? x2_ff : x1_ff;
   assign ylo = (y1_ff < y2_ff) ? y1_ff : y2_ff;
   assign yhi = (y1_ff < y2_ff) ? y2_ff : y1_ff;

   // Byte limit: width rounded up to whole bytes times height, capped at the store.
   assign limit_raw = IDX_W'((10'(width_px) + 10'd7) >> 3) * IDX_W'(height_px);
   assign limit_now = (limit_raw > DEPTH_IDX) ? DEPTH_IDX : limit_raw;

   always_comb begin
      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      axis_v_in = axis_v_ff;
      if (cmd.seg_h) begin
         cur_x_in  = xlo;
         axis_v_in = 1'b0;
         unique case (cmd.row_sel)
            ROW_Y1:   cur_y_in = y1_ff;
            ROW_Y2:   cur_y_in = y2_ff;
            ROW_LO:   cur_y_in = ylo;
            default:  cur_y_in = cur_y_ff + 10'sd1;
         endcase
      end else if (cmd.seg_v) begin
         cur_x_in  = cmd.col_x2 ? x2_ff : x1_ff;
         cur_y_in  = ylo;
         axis_v_in = 1'b1;
      end else if (cmd.step) begin
         if (axis_v_ff) begin
            cur_y_in = cur_y_ff + 10'sd1;
         end else begin
            cur_x_in = cur_x_ff + 10'sd1;
         end
      end
   end

   assign x_in_range = !cur_x_ff[9] && (cur_x_ff[8:0] < width_px);
   assign y_in_range = !cur_y_ff[9] && (cur_y_ff[8:0] < {2'b00, height_px});
   assign page_off   = 15'(cur_y_ff[8:3]) * 15'(width_px);
   assign idx_now    = IDX_W'(cur_x_ff[8:0]) + IDX_W'(page_off);

   always_ff @(posedge clock) begin
      limit_ff  <= limit_now;
      pix_ok_ff <= x_in_range && y_in_range && (idx_now < limit_ff);
      idx_ff    <= idx_now;
      mask_ff   <= 8'h80 >> cur_y_ff[2:0];
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      axis_v_ff <= axis_v_in;
      if (cmd.load) begin
         x1_ff   <= req_x1;
         y1_ff   <= req_y1;
         addr_ff <= req_byte_addr;
         // A single pixel is a one-pixel line at the first point.
         if (action_type'(req_action) == ACT_PIXEL) begin
            x2_ff <= req_x1;
            y2_ff <= req_y1;
         end else begin
            x2_ff <= req_x2;
            y2_ff <= req_y2;
         end
      end
      if (cmd.clr_start) begin
         cnt_ff <= '0;
         end_ff <= cmd.clr_full ? CW'(STORE_DEPTH) : CW'(limit_now);
      end else if (cmd.clr_step) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   assign byte_idx  = IDX_W'(addr_ff);
   assign ram_we    = cmd.clr_step || cmd.wr_pix;
   assign ram_waddr = cmd.clr_step ? cnt_ff[AW-1:0] : idx_ff[AW-1:0];
   assign ram_wdata = cmd.clr_step ? 8'h00 : (ram_rdata | mask_ff);
   assign ram_re    = cmd.rd_pix || cmd.rd_byte;
   assign ram_raddr = cmd.rd_byte ? byte_idx[AW-1:0] : idx_ff[AW-1:0];

   pmfd_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_ok_ff   <= cmd.rsp_ok;
         rsp_data_ff <= cmd.rsp_rd ? ram_rdata : 8'h00;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_read_data = rsp_data_ff;

   assign status.seg_last = axis_v_ff ? (cur_y_ff == yhi) : (cur_x_ff == xhi);
   assign status.row_last = (cur_y_ff == yhi);
   assign status.pix_ok   = pix_ok_ff;
   assign status.clr_done = (cnt_ff >= end_ff);
   assign status.addr_ok  = (byte_idx < DEPTH_IDX);
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

endmodule

FILE: rtl/paged_mono_framebuffer_draw_top.sv
// ---------------------------------------------------------------------------
// paged_mono_framebuffer_draw_top
// Draw engine over a one-bit display store arranged in pages of eight rows.
// ---------------------------------------------------------------------------
// A request on req_port carries an action and its coordinates; each request
// yields exactly one response on rsp_port with an ok flag and, for a read,
// the store byte. Width and height registers are written over the APB port
// (width at byte 0, height at byte 4); the user must write them only while
// the engine is idle, since the block itself does not enforce this.
// Each pixel passes three steps: check and index, a store read, and a write
// back of the merged byte. A line walks its pixels in order, a filled
// rectangle row by row, clear one covered byte at a time, and a read is a
// single store read.
// One request is processed at a time; the next request is taken as soon as
// the engine returns to idle, even while the last response waits.
// After reset the store is swept to zero, one byte per cycle, over all
// MAX_WIDTH*MAX_PAGES bytes, during which no request is accepted.
// When the receiver stalls, the response is held in its output register and
// a finished request waits for that register before the engine goes idle.
// ---------------------------------------------------------------------------
module paged_mono_framebuffer_draw_top #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_PAGES = 8
) (
   input  logic        clock,
   input  logic        reset,
   draw_req_if.sink    req_port,
   draw_rsp_if.source  rsp_port,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import pmfd_pkg::*;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_PAGES;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic                wr_en;
   cmd_type             cmd;
   status_type          status;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_W'(256);
         height_ff <= HEIGHT_W'(64);
      end else if (wr_en) begin
         if (paddr[2]) begin
            height_ff <= pwdata[HEIGHT_W-1:0];
         end else begin
            width_ff <= pwdata[WIDTH_W-1:0];
         end
      end
   end

   assign prdata = paddr[2] ? 32'(height_ff) : 32'(width_ff);

   pmfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_port.valid),
      .req_action (req_port.action),
      .req_ready  (req_port.ready),
      .status     (status),
      .cmd        (cmd)
   );

   pmfd_dp #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_action    (req_port.action),
      .req_x1        (req_port.x1),
      .req_y1        (req_port.y1),
      .req_x2        (req_port.x2),
      .req_y2        (req_port.y2),
      .req_byte_addr (req_port.byte_addr),
      .width_px      (width_ff),
      .height_px     (height_ff),
      .rsp_valid     (rsp_port.valid),
      .rsp_ready     (rsp_port.ready),
      .rsp_ok        (rsp_port.ok),
      .rsp_read_data (rsp_port.read_data)
   );

endmodule
